// ===== src/assert_macros.svh =====
// Assertion macros for the checker file of the dimmer block.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define DBD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dimmer assertion failed");

// Next-cycle implication, disabled while reset is high.
`define DBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dimmer assertion failed");

`endif

// ===== src/dbd_pkg.sv =====
// Shared types and constants for the debounced button PWM dimmer.
// Used by the interfaces, the sub-blocks and the top level.
package dbd_pkg;

  localparam int BTN_W      = 2;
  localparam int STEP_W     = 3;
  localparam int DEB_W      = 11;
  localparam int CNT_W      = 12;
  localparam int LVL_W      = 8;
  localparam int LVL_REGS   = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_0  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_1  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_2  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_3  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_4  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_5  = 3'd6;

  // Button patterns (bit 0 down, bit 1 up).
  localparam logic [BTN_W-1:0] BTN_NONE = 2'b00;
  localparam logic [BTN_W-1:0] BTN_DOWN = 2'b01;
  localparam logic [BTN_W-1:0] BTN_UP   = 2'b10;
  localparam logic [BTN_W-1:0] BTN_BOTH = 2'b11;

  localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 11'h400;

  typedef logic [LVL_REGS-1:0][LVL_W-1:0] level_arr_t;

  localparam level_arr_t LEVEL_RESET = {8'h40, 8'h20, 8'h10, 8'h04, 8'h02, 8'h00};

  typedef struct packed {
    logic [DEB_W-1:0] debounce_ticks;
    level_arr_t       level;
  } cfg_t;

endpackage

// ===== src/dbd_if.sv =====
// Valid/ready channel interfaces for button samples and dimmer results.
// Depends on dbd_pkg.
interface dbd_in_if;
  import dbd_pkg::*;

  logic             valid;
  logic             ready;
  logic [BTN_W-1:0] buttons;

  modport source (output valid, output buttons, input ready);
  modport sink (input valid, input buttons, output ready);
endinterface

interface dbd_out_if;
  import dbd_pkg::*;

  logic              valid;
  logic              ready;
  logic              led_on;
  logic [STEP_W-1:0] current_step;

  modport source (output valid, output led_on, output current_step, input ready);
  modport sink (input valid, input led_on, input current_step, output ready);
endinterface

// ===== src/dbd_cfg_regs.sv =====
// Configuration register file: debounce threshold and six PWM level values.
// Depends on dbd_pkg.
module dbd_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [dbd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dbd_pkg::CFG_DATA_W-1:0] cfg_data,
  output dbd_pkg::cfg_t                  cfg
);
  import dbd_pkg::*;

  cfg_t cfg_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg.debounce_ticks <= DEBOUNCE_RESET;
      cfg_reg.level          <= LEVEL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEBOUNCE: cfg_reg.debounce_ticks <= cfg_data[DEB_W-1:0];
        REG_LEVEL_0:  cfg_reg.level[0] <= cfg_data[LVL_W-1:0];
        REG_LEVEL_1:  cfg_reg.level[1] <= cfg_data[LVL_W-1:0];
        REG_LEVEL_2:  cfg_reg.level[2] <= cfg_data[LVL_W-1:0];
        REG_LEVEL_3:  cfg_reg.level[3] <= cfg_data[LVL_W-1:0];
        REG_LEVEL_4:  cfg_reg.level[4] <= cfg_data[LVL_W-1:0];
        REG_LEVEL_5:  cfg_reg.level[5] <= cfg_data[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_reg;

endmodule

// ===== src/dbd_debounce.sv =====
// Button debouncer: qualifies a stable, nonzero pattern as one press.
// Depends on dbd_pkg.
module dbd_debounce (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic [dbd_pkg::BTN_W-1:0] buttons,
  input  logic [dbd_pkg::DEB_W-1:0] debounce_ticks,
  output logic [dbd_pkg::BTN_W-1:0] press
);
  import dbd_pkg::*;

  logic [CNT_W-1:0] stable_count;
  logic [CNT_W-1:0] stable_count_next;
  logic [BTN_W-1:0] last_buttons;
  logic [CNT_W-1:0] ticks_ext;

  assign ticks_ext = {{(CNT_W-DEB_W){1'b0}}, debounce_ticks};

  // The count fires once on reaching the threshold and then sits above it,
  // so a held pattern presses exactly once.
  always_comb begin
    stable_count_next = stable_count;
    press             = BTN_NONE;
    if (buttons == BTN_NONE || buttons != last_buttons) begin
      stable_count_next = '0;
    end else if (stable_count < ticks_ext) begin
      stable_count_next = stable_count + 1'b1;
    end else if (stable_count == ticks_ext) begin
      stable_count_next = stable_count + 1'b1;
      press             = buttons;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable_count <= '0;
      last_buttons <= BTN_NONE;
    end else if (en) begin
      stable_count <= stable_count_next;
      last_buttons <= buttons;
    end
  end

endmodule

// ===== src/dbd_dimmer.sv =====
// Brightness step tracker and PWM phase counter with the LED compare.
// Depends on dbd_pkg.
module dbd_dimmer #(
  parameter int PWM_BITS   = 6,
  parameter int NUM_LEVELS = 6
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic [dbd_pkg::BTN_W-1:0]  press,
  input  dbd_pkg::level_arr_t        level,
  output logic                       led_on,
  output logic [dbd_pkg::STEP_W-1:0] step_next
);
  import dbd_pkg::*;

  localparam int CMP_W = (PWM_BITS > LVL_W) ? PWM_BITS : LVL_W;
  localparam logic [STEP_W-1:0] STEP_MAX  = STEP_W'(NUM_LEVELS - 1);
  localparam logic [STEP_W-1:0] STEP_BOTH = STEP_W'(NUM_LEVELS - 2);

  logic [PWM_BITS-1:0] pwm_phase;
  logic [STEP_W-1:0]   level_index;
  logic [CMP_W-1:0]    phase_ext;
  logic [CMP_W-1:0]    level_ext;

  // The compare uses the step held before this item's button handling.
  assign phase_ext = CMP_W'(pwm_phase);
  assign level_ext = CMP_W'(level[level_index]);
  assign led_on    = (phase_ext < level_ext);

  always_comb begin
    step_next = level_index;
    case (press)
      BTN_DOWN: if (level_index != '0) step_next = level_index - 1'b1;
      BTN_UP:   if (level_index < STEP_MAX) step_next = level_index + 1'b1;
      BTN_BOTH: step_next = (level_index == '0) ? STEP_BOTH : '0;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_phase   <= '0;
      level_index <= '0;
    end else if (en) begin
      pwm_phase   <= pwm_phase + 1'b1;
      level_index <= step_next;
    end
  end

endmodule

// ===== src/debounced_button_pwm_dimmer_top.sv =====
// Each accepted button sample is one tick: its result (LED drive and the
// brightness step after the button handling) appears in the output register
// on the next cycle, and a new sample is taken every cycle, including while
// a finished result waits, as long as that result is taken in the same cycle.
// The sustained rate is one item per cycle while results are taken; the
// single output register is what sets it. Configuration is ready at reset
// and needs no clearing pass. Depends on dbd_pkg, the channel interfaces,
// dbd_cfg_regs, dbd_debounce and dbd_dimmer.
module debounced_button_pwm_dimmer_top #(
  parameter int PWM_BITS   = 6,
  parameter int NUM_LEVELS = 6
) (
  input  logic                           clk,
  input  logic                           rst,
  dbd_in_if.sink                         btn_in,
  dbd_out_if.source                      res_out,
  input  logic                           cfg_we,
  input  logic [dbd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dbd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dbd_pkg::*;

  cfg_t              cfg;
  logic              accept;
  logic [BTN_W-1:0]  press;
  logic              led_on_comb;
  logic [STEP_W-1:0] step_comb;
  logic              out_valid;
  logic              led_on;
  logic [STEP_W-1:0] current_step;

  assign btn_in.ready = !out_valid || res_out.ready;
  assign accept       = btn_in.valid && btn_in.ready;

  dbd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dbd_debounce u_debounce (
    .clk            (clk),
    .rst            (rst),
    .en             (accept),
    .buttons        (btn_in.buttons),
    .debounce_ticks (cfg.debounce_ticks),
    .press          (press)
  );

  dbd_dimmer #(
    .PWM_BITS   (PWM_BITS),
    .NUM_LEVELS (NUM_LEVELS)
  ) u_dimmer (
    .clk       (clk),
    .rst       (rst),
    .en        (accept),
    .press     (press),
    .level     (cfg.level),
    .led_on    (led_on_comb),
    .step_next (step_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (res_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      led_on       <= led_on_comb;
      current_step <= step_comb;
    end
  end

  assign res_out.valid        = out_valid;
  assign res_out.led_on       = led_on;
  assign res_out.current_step = current_step;

endmodule

// ===== src/dbd_checker.sv =====
// Port-level checks for the dimmer top level, attached by a bind statement.
// Depends on dbd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dbd_checker #(
  parameter int NUM_LEVELS = 6
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       led_on,
  input logic [dbd_pkg::STEP_W-1:0] current_step
);
  import dbd_pkg::*;

  localparam logic [STEP_W-1:0] STEP_MAX = STEP_W'(NUM_LEVELS - 1);

  `DBD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `DBD_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(led_on) && $stable(current_step))
  `DBD_ASSERT_NEXT(a_transfer_gives_result, clk, rst, in_valid && in_ready, out_valid)
  `DBD_ASSERT_NOW(a_step_range, clk, rst, out_valid, current_step <= STEP_MAX)

endmodule

bind debounced_button_pwm_dimmer_top dbd_checker #(
  .NUM_LEVELS (NUM_LEVELS)
) u_dbd_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (btn_in.valid),
  .in_ready     (btn_in.ready),
  .out_valid    (res_out.valid),
  .out_ready    (res_out.ready),
  .led_on       (res_out.led_on),
  .current_step (res_out.current_step)
);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the debounced button PWM dimmer top level.
// Drives button samples with bursts and gaps, predicts LED and step per tick,
// and checks every result transfer. Depends on dbd_pkg, dbd_if and the RTL.
module tb;
  import dbd_pkg::*;

  localparam int PWM_BITS   = 6;
  localparam int NUM_LEVELS = 6;
  // Index past the last register: the write must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  typedef struct {
    logic              led;
    logic [STEP_W-1:0] step;
  } led_step_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  dbd_in_if  btn_if ();
  dbd_out_if res_if ();

  debounced_button_pwm_dimmer_top #(
    .PWM_BITS  (PWM_BITS),
    .NUM_LEVELS(NUM_LEVELS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .btn_in   (btn_if),
    .res_out  (res_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Mirror of the block's registers and state.
  logic [DEB_W-1:0]    deb_ticks;
  logic [LVL_W-1:0]    level_val [LVL_REGS];
  logic [PWM_BITS-1:0] phase;
  logic [STEP_W-1:0]   step;
  logic [CNT_W-1:0]    stable_cnt;
  logic [BTN_W-1:0]    last_btn;

  logic [BTN_W-1:0] btn_stream [$];
  led_step_t        due_results [$];
  int               mismatches = 0;
  int               burst_left = 0;
  int               gap_left = 0;
  int               ready_left = 0;
  logic [7:0]       ready_pat = 8'hFF;

  initial begin
    forever #2 clk = ~clk;
  end

  // One tick: the LED compare uses the step held before the button handling.
  function automatic void advance_dimmer(logic [BTN_W-1:0] btn);
    logic [BTN_W-1:0] press;
    int               sel;
    led_step_t        res;
    sel = (step >= NUM_LEVELS) ? NUM_LEVELS - 1 : step;
    res.led = ({2'b00, phase} < level_val[sel]);
    press = BTN_NONE;
    if (btn == BTN_NONE || btn != last_btn) begin
      stable_cnt = '0;
      last_btn   = btn;
    end else if (stable_cnt < deb_ticks) begin
      stable_cnt = stable_cnt + 1'b1;
    end else if (stable_cnt == deb_ticks) begin
      stable_cnt = stable_cnt + 1'b1;
      press      = btn;
    end
    case (press)
      BTN_DOWN: begin
        if (step > 0) step = step - 1'b1;
      end
      BTN_UP: begin
        if (step < NUM_LEVELS - 1) step = step + 1'b1;
      end
      BTN_BOTH: begin
        step = (step == 0) ? STEP_W'(NUM_LEVELS - 2) : '0;
      end
      default: ;
    endcase
    phase = phase + 1'b1;
    res.step = step;
    due_results.push_back(res);
  endfunction

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      btn_if.valid <= 1'b0;
      burst_left   <= 0;
      gap_left     <= 0;
    end else begin
      if (btn_if.valid && btn_if.ready) advance_dimmer(btn_if.buttons);
      if (!btn_if.valid || btn_if.ready) begin
        if (gap_left != 0) begin
          gap_left     <= gap_left - 1;
          btn_if.valid <= 1'b0;
        end else if (btn_stream.size() != 0) begin
          btn_if.valid   <= 1'b1;
          btn_if.buttons <= btn_stream.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(24, 1);
            gap_left   <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(5, 1);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          btn_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: ready follows a rotating 8-bit pattern that is redrawn every so
  // often; bit 0 is forced high so ready is high once in each turn of it.
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
      ready_left   <= 0;
    end else if (ready_left == 0) begin
      ready_pat    <= ($urandom_range(2, 0) == 0) ? 8'hFF : (8'($urandom()) | 8'h01);
      ready_left   <= $urandom_range(80, 20);
      res_if.ready <= 1'b1;
    end else begin
      res_if.ready <= ready_pat[0];
      ready_pat    <= {ready_pat[0], ready_pat[7:1]};
      ready_left   <= ready_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) begin
      if (due_results.size() == 0) begin
        $error("result transfer with nothing expected");
        mismatches++;
      end else begin
        led_step_t want;
        want = due_results.pop_front();
        if (res_if.led_on !== want.led) begin
          $error("led_on: expected %0d, got %0d", want.led, res_if.led_on);
          mismatches++;
        end
        if (res_if.current_step !== want.step) begin
          $error("current_step: expected %0d, got %0d", want.step, res_if.current_step);
          mismatches++;
        end
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_DEBOUNCE) deb_ticks = data[DEB_W-1:0];
    else if (idx <= REG_LEVEL_5) level_val[idx - REG_LEVEL_0] = data[LVL_W-1:0];
  endtask

  task automatic push_btn(logic [BTN_W-1:0] btn, int count);
    @(negedge clk);
    repeat (count) btn_stream.push_back(btn);
  endtask

  // Wait until every sample has been taken and every result checked, then
  // let the pipeline settle.
  task automatic drain();
    @(negedge clk);
    while (btn_stream.size() != 0 || btn_if.valid || due_results.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_level();
    logic [LVL_W-1:0] lvl;
    case ($urandom_range(5, 0))
      0: lvl = 8'd0;
      1: lvl = 8'd63;
      2: lvl = 8'd64;
      3: lvl = 8'd255;
      default: lvl = LVL_W'($urandom_range(255, 0));
    endcase
    // Upper data bits are random: a level register keeps only its low byte.
    return {3'($urandom_range(7, 0)), lvl};
  endfunction

  // Mostly clean holds long enough to press, with short holds, direct pattern
  // changes and bouncing noise mixed in.
  task automatic queue_press_runs(int n_items);
    int               queued;
    int               hold;
    logic [BTN_W-1:0] pat;
    queued = 0;
    @(negedge clk);
    while (queued < n_items) begin
      if ($urandom_range(9, 0) < 7) begin
        pat  = BTN_W'($urandom_range(3, 1));
        hold = ($urandom_range(4, 0) == 0) ? $urandom_range(deb_ticks + 1, 1)
                                          : deb_ticks + 1 + $urandom_range(3, 0);
        repeat (hold) btn_stream.push_back(pat);
        queued += hold;
        if ($urandom_range(1, 0) == 0) begin
          hold = $urandom_range(2, 1);
          repeat (hold) btn_stream.push_back(BTN_NONE);
          queued += hold;
        end
      end else begin
        hold = $urandom_range(4, 1);
        repeat (hold) btn_stream.push_back(BTN_BTN_RAND());
        queued += hold;
      end
    end
  endtask

  function automatic logic [BTN_W-1:0] BTN_BTN_RAND();
    return BTN_W'($urandom_range(3, 0));
  endfunction

  initial begin
    deb_ticks  = DEBOUNCE_RESET;
    for (int i = 0; i < LVL_REGS; i++) level_val[i] = LEVEL_RESET[i];
    phase      = '0;
    step       = '0;
    stable_cnt = '0;
    last_btn   = BTN_NONE;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset configuration: no press can qualify this soon.
    repeat (10) push_btn(BTN_BTN_RAND(), 1);
    drain();

    // Shortest debounce: every step move, both limits and the both-buttons jump.
    write_reg(REG_DEBOUNCE, 11'd0);
    write_reg(REG_LEVEL_0, 11'h7FF);
    write_reg(REG_LEVEL_1, 11'd0);
    write_reg(REG_LEVEL_2, 11'd63);
    write_reg(REG_LEVEL_3, 11'd64);
    write_reg(REG_LEVEL_4, 11'd1);
    write_reg(REG_LEVEL_5, 11'd32);
    write_reg(REG_SPARE, 11'h7FF);
    push_btn(BTN_DOWN, 2);
    push_btn(BTN_UP, 3);
    push_btn(BTN_NONE, 1);
    push_btn(BTN_UP, 2);
    push_btn(BTN_BOTH, 3);
    push_btn(BTN_NONE, 1);
    push_btn(BTN_BOTH, 2);
    push_btn(BTN_UP, 2);
    push_btn(BTN_NONE, 1);
    push_btn(BTN_UP, 2);
    push_btn(BTN_DOWN, 2);
    push_btn(BTN_BOTH, 2);
    drain();

    // Threshold lowered below a running count: the held pattern never presses.
    write_reg(REG_DEBOUNCE, 11'd20);
    push_btn(BTN_UP, 10);
    drain();
    write_reg(REG_DEBOUNCE, 11'd3);
    push_btn(BTN_UP, 10);
    push_btn(BTN_NONE, 1);
    push_btn(BTN_UP, 5);
    drain();

    // Long debounce: one press after a long steady hold.
    write_reg(REG_DEBOUNCE, 11'd600);
    push_btn(BTN_UP, 603);
    push_btn(BTN_NONE, 1);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_DEBOUNCE, CFG_DATA_W'(($urandom_range(3, 0) == 0) ? $urandom_range(40, 7)
                                                                     : $urandom_range(6, 0)));
      for (int r = 0; r < LVL_REGS; r++) write_reg(CFG_IDX_W'(REG_LEVEL_0 + r), pick_level());
      if (ph % 4 == 0) write_reg(REG_SPARE, CFG_DATA_W'($urandom_range(2047, 0)));
      queue_press_runs(90);
      drain();
    end

    repeat (5) @(posedge clk);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb failed");
    $finish;
  end

endmodule

// ===== debounced_button_pwm_dimmer_top.f =====
+incdir+src
src/dbd_pkg.sv
src/dbd_if.sv
src/dbd_cfg_regs.sv
src/dbd_debounce.sv
src/dbd_dimmer.sv
src/debounced_button_pwm_dimmer_top.sv
src/dbd_checker.sv
verif/tb.sv
